// ===== hw/rtl/mstw_pkg.sv =====
// ----------------------------------------------------------------------------
// mstw_pkg: shared constants and types of the minimum spanning tree block
// Field widths of the stream beats and default sizes of the two stores.
// ----------------------------------------------------------------------------
package mstw_pkg;

    localparam int NODE_W          = 9;
    localparam int WEIGHT_W        = 16;
    localparam int SUM_W           = 24;
    localparam int CFG_W           = 9;
    localparam int EDGE_W          = 2 * NODE_W + WEIGHT_W;
    localparam int IN_TDATA_W      = ((EDGE_W + 7) / 8) * 8;
    localparam int MAX_NODES_DEF   = 256;
    localparam int MAX_EDGES_DEF   = 1024;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   to;
        logic [NODE_W-1:0]   from;
    } t_edge;

endpackage

// ===== hw/rtl/mstw_ram.sv =====
// ----------------------------------------------------------------------------
// mstw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mstw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/minimum_spanning_tree_weight.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight: MST total weight over a streamed edge list
// Edges are buffered in an edge RAM; a union-find forest in a parent RAM
// decides which edges join the tree, visited in ascending weight order.
// ----------------------------------------------------------------------------
// Usage: each slave-side beat carries one edge {from, to, weight}; tlast marks
// the final edge of a graph. node_count is set through the APB port; the user
// must write it only while the block is idle, the block itself does not enforce it.
// Edges load at one beat per cycle while idle. After the tlast beat the slave
// side deasserts tready and the job runs: a clearing pass writes every parent
// entry to itself, then the edge RAM is scanned once to find the smallest
// weight and once more per distinct weight. Each scan reads every stored edge,
// plus the root walks of the edges of the current weight, one parent RAM read
// per step. One master-side beat follows: tdata holds the tree weight (zero
// when disconnected), tuser the disconnected flag. The result sits in an
// output register; new edges are taken while it waits, but the next job's
// result waits until it has been taken.
// Reset empties the edge store and sets node_count to 1. Edges beyond
// MAX_EDGES are dropped.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_weight #(
    parameter int MAX_NODES = mstw_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = mstw_pkg::MAX_EDGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: tdata = edge_from[8:0], edge_to[17:9], weight[33:18], zero pad.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [mstw_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic        i_s_tlast,
    // Master side: tdata = total_weight[23:0]; tuser = disconnected[0].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [mstw_pkg::SUM_W-1:0] o_m_tdata,
    output logic        o_m_tuser,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int NAW = $clog2(MAX_NODES + 1);
    localparam int CW  = mstw_pkg::NODE_W + NAW;
    localparam int WW  = mstw_pkg::WEIGHT_W;
    localparam int SW  = mstw_pkg::SUM_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EDGE = 3'd3;
    localparam logic [2:0] S_FA   = 3'd4;
    localparam logic [2:0] S_FB   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]                  r_state, n_state;
    logic [mstw_pkg::CFG_W-1:0]  r_cfg;
    logic [ECW-1:0]              r_cnt, n_cnt;
    logic [ECW-1:0]              r_idx, n_idx;
    logic [NAW-1:0]              r_clr, n_clr;
    logic [NAW-1:0]              r_n, n_n;
    logic [NAW-1:0]              r_comps, n_comps;
    logic [NAW-1:0]              r_x, n_x;
    logic [NAW-1:0]              r_ra, n_ra;
    logic [mstw_pkg::NODE_W-1:0] r_to, n_to;
    logic [WW-1:0]               r_w, n_w;
    logic [WW-1:0]               r_cur, n_cur;
    logic [WW-1:0]               r_next, n_next;
    logic                        r_have_cur, n_have_cur;
    logic                        r_have_next, n_have_next;
    logic [SW-1:0]               r_sum, n_sum;
    logic                        r_ovalid, n_ovalid;
    logic [SW-1:0]               r_otot, n_otot;
    logic                        r_odisc, n_odisc;

    mstw_pkg::t_edge             in_edge, e_rd;
    logic                        e_we;
    logic [EAW-1:0]              e_raddr;
    logic                        p_we;
    logic [NAW-1:0]              p_waddr, p_wdata, p_raddr, p_rd;
    logic                        in_acc, out_acc, cfg_wr;
    logic                        from_ok, to_ok;
    logic [SW:0]                 sum_ext;

    assign in_edge    = i_s_tdata[mstw_pkg::EDGE_W-1:0];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = r_ovalid && i_m_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_otot;
    assign o_m_tuser  = r_odisc;

    // Configuration port: any address with paddr[2] low is node_count.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - mstw_pkg::CFG_W){1'b0}}, r_cfg} : 32'd0;

    assign from_ok = (e_rd.from != '0) && (CW'(e_rd.from) <= CW'(r_n));
    assign to_ok   = (e_rd.to != '0) && (CW'(e_rd.to) <= CW'(r_n));
    assign sum_ext = {1'b0, r_sum} + (SW + 1)'(r_w);

    mstw_ram #(.WIDTH(mstw_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_cnt[EAW-1:0]),
        .i_wdata (in_edge),
        .i_raddr (e_raddr),
        .o_rdata (e_rd)
    );

    mstw_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES + 1)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_clr       = r_clr;
        n_n         = r_n;
        n_comps     = r_comps;
        n_x         = r_x;
        n_ra        = r_ra;
        n_to        = r_to;
        n_w         = r_w;
        n_cur       = r_cur;
        n_next      = r_next;
        n_have_cur  = r_have_cur;
        n_have_next = r_have_next;
        n_sum       = r_sum;
        n_ovalid    = r_ovalid && !out_acc;
        n_otot      = r_otot;
        n_odisc     = r_odisc;
        e_we        = 1'b0;
        e_raddr     = r_idx[EAW-1:0];
        p_we        = 1'b0;
        p_waddr     = r_clr;
        p_wdata     = r_clr;
        p_raddr     = r_x;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_cnt < ECW'(MAX_EDGES)) begin
                        e_we  = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_clr   = '0;
                        n_state = S_CLR;
                        // Effective node count: zero reads as one, saturate high.
                        if (r_cfg == '0) begin
                            n_n = NAW'(1);
                        end else if (CW'(r_cfg) > CW'(MAX_NODES)) begin
                            n_n = NAW'(MAX_NODES);
                        end else begin
                            n_n = NAW'(r_cfg);
                        end
                    end
                end
            end
            S_CLR: begin
                p_we  = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == NAW'(MAX_NODES)) begin
                    n_idx       = '0;
                    n_have_cur  = 1'b0;
                    n_have_next = 1'b0;
                    n_comps     = r_n;
                    n_sum       = '0;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                if (r_idx == r_cnt) begin
                    if (r_have_next) begin
                        n_cur       = r_next;
                        n_have_cur  = 1'b1;
                        n_have_next = 1'b0;
                        n_idx       = '0;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                n_to = e_rd.to;
                n_w  = e_rd.weight;
                if ((!r_have_cur || e_rd.weight > r_cur) &&
                    (!r_have_next || e_rd.weight < r_next)) begin
                    n_next      = e_rd.weight;
                    n_have_next = 1'b1;
                end
                if (r_have_cur && e_rd.weight == r_cur && from_ok && to_ok) begin
                    n_x     = NAW'(e_rd.from);
                    p_raddr = NAW'(e_rd.from);
                    n_state = S_FA;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_FA: begin
                if (p_rd == r_x) begin
                    n_ra    = r_x;
                    n_x     = NAW'(r_to);
                    p_raddr = NAW'(r_to);
                    n_state = S_FB;
                end else begin
                    n_x     = p_rd;
                    p_raddr = p_rd;
                end
            end
            S_FB: begin
                if (p_rd == r_x) begin
                    if (r_ra != r_x) begin
                        p_we    = 1'b1;
                        p_waddr = r_ra;
                        p_wdata = r_x;
                        n_comps = r_comps - 1'b1;
                        n_sum   = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end else begin
                    n_x     = p_rd;
                    p_raddr = p_rd;
                end
            end
            S_FIN: begin
                if (!r_ovalid || out_acc) begin
                    n_ovalid = 1'b1;
                    n_odisc  = (r_comps > NAW'(1));
                    n_otot   = (r_comps > NAW'(1)) ? '0 : r_sum;
                    n_cnt    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_cfg    <= mstw_pkg::CFG_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (cfg_wr) begin
                r_cfg <= pwdata[mstw_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_clr       <= n_clr;
        r_n         <= n_n;
        r_comps     <= n_comps;
        r_x         <= n_x;
        r_ra        <= n_ra;
        r_to        <= n_to;
        r_w         <= n_w;
        r_cur       <= n_cur;
        r_next      <= n_next;
        r_have_cur  <= n_have_cur;
        r_have_next <= n_have_next;
        r_sum       <= n_sum;
        r_otot      <= n_otot;
        r_odisc     <= n_odisc;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ECW'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_union_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FB && p_we) |-> (r_ra != r_x && p_rd == r_x))
        else $error("parent link written between non-roots or within one set");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_ovalid || out_acc)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished job did not load the result register");

    a_comps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_FIN) |-> (r_comps != '0 && r_comps <= r_n))
        else $error("component count out of range");
`endif

endmodule
